@@ sv/bscr_pkg.sv @@
package bscr_pkg;

  localparam int RAW_W      = 12;
  localparam int MV_W       = 13;
  localparam int PCT_W      = 7;
  localparam int COL_W      = 6;
  localparam int BITS_W     = 8;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int NUM_W      = 20;
  localparam int CV_W       = 10;
  localparam int CVT_W      = 6;
  localparam int DIGIT_W    = 4;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 40;
  localparam int TEXT_SLOTS = 10;
  localparam int LEN_W      = 4;
  localparam int FONT_HEIGHT = 5;
  localparam int TOP_ROW    = 3;

  localparam int DEF_FRAME_COLUMNS = 44;

  // mv = (raw*74025 + 25600) / 51200, done as >> 11 then / 25
  localparam int MV_SCALE        = 74025;
  localparam int MV_BIAS         = 25600;
  localparam int MV_SHIFT        = 11;
  localparam int DIV25_MUL       = 335545;
  localparam int DIV25_SHIFT     = 23;
  localparam int DIV10_MUL       = 6554;
  localparam int DIV10_SHIFT     = 16;
  localparam int PCT_DIV10_MUL   = 205;
  localparam int PCT_DIV10_SHIFT = 11;
  localparam int CV_ROUND        = 5;
  localparam int CV_MAX          = 599;
  localparam int PCT_FULL        = 100;
  localparam int RADIX           = 10;

  localparam logic [CFG_W-1:0] EMPTY_MV_RESET = 13'd3300;
  localparam logic [CFG_W-1:0] FULL_MV_RESET  = 13'd4200;

  localparam logic [CFG_IDX_W-1:0] REG_EMPTY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL  = 1'b1;

  typedef logic [DIGIT_W-1:0] glyph_t;

  localparam glyph_t GLYPH_ZERO  = 4'd0;
  localparam glyph_t GLYPH_ONE   = 4'd1;
  localparam glyph_t GLYPH_DOT   = 4'd10;
  localparam glyph_t GLYPH_VOLT  = 4'd11;
  localparam glyph_t GLYPH_SPACE = 4'd12;
  localparam glyph_t GLYPH_PCT   = 4'd13;

  typedef struct packed {
    logic [MV_W-1:0]    mv;
    logic [CVT_W-1:0]   cv_tens;
    logic [DIGIT_W-1:0] cv_hund;
    logic [DIGIT_W-1:0] cv_ones;
    logic               is_low;
    logic               is_high;
  } side_t;

  typedef struct packed {
    glyph_t [TEXT_SLOTS-1:0] text;
    logic [LEN_W-1:0]        len;
    logic [COL_W-1:0]        start;
    logic [MV_W-1:0]         mv;
    logic [PCT_W-1:0]        pct;
  } frame_t;

  // rows top to bottom, row 0 in the high bits, msb of a row is the left pixel
  function automatic logic [FONT_HEIGHT-1:0] glyph_column(glyph_t code, logic [1:0] x);
    logic [14:0]            rows;
    logic [FONT_HEIGHT-1:0] col;
    int                     xi;
    case (code)
      4'd0:        rows = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      4'd1:        rows = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
      4'd2:        rows = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      4'd3:        rows = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      4'd4:        rows = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      4'd5:        rows = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      4'd6:        rows = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      4'd7:        rows = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
      4'd8:        rows = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      4'd9:        rows = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      GLYPH_DOT:   rows = {3'd0, 3'd0, 3'd0, 3'd0, 3'd2};
      GLYPH_VOLT:  rows = {3'd5, 3'd5, 3'd5, 3'd5, 3'd2};
      GLYPH_PCT:   rows = {3'd5, 3'd1, 3'd2, 3'd4, 3'd5};
      default:     rows = '0;
    endcase
    xi = int'(x);
    for (int y = 0; y < FONT_HEIGHT; y++) begin
      col[y] = (xi == 3) ? 1'b0 : rows[14 - 3 * y - xi];
    end
    return col;
  endfunction

endpackage

@@ sv/bscr_front.sv @@
module bscr_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [bscr_pkg::RAW_W-1:0]         raw_sample,
  input  logic                               cfg_write,
  input  logic [bscr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bscr_pkg::CFG_W-1:0]         cfg_data,
  output logic                               out_valid,
  output logic [bscr_pkg::NUM_W-1:0]         num,
  output logic [bscr_pkg::MV_W-1:0]          span,
  output bscr_pkg::side_t                    side
);

  logic [bscr_pkg::CFG_W-1:0] empty_mv;
  logic [bscr_pkg::CFG_W-1:0] full_mv;

  logic v1, v2, v3, v4;

  logic [17:0]                    y1;
  logic [bscr_pkg::MV_W-1:0]      mv2;
  logic [bscr_pkg::MV_W-1:0]      mv3, mv4;
  logic [bscr_pkg::NUM_W-1:0]     num3, num4;
  logic [bscr_pkg::MV_W-1:0]      span3, span4;
  logic                           low3, low4, high3, high4;
  logic [bscr_pkg::CV_W-1:0]      cv3, cv4;
  logic [bscr_pkg::CVT_W-1:0]     h4;

  logic [28:0]                    prod1;
  logic [36:0]                    prod2;
  logic [bscr_pkg::MV_W-1:0]      diff_c, span_c, mvr_c;
  logic [bscr_pkg::NUM_W-1:0]     num_c;
  logic [25:0]                    cv_prod;
  logic [bscr_pkg::CV_W-1:0]      cv_q, cv_c;
  logic [22:0]                    h_prod;
  logic [18:0]                    hund_prod;
  logic [bscr_pkg::CV_W-1:0]      ones_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_mv <= bscr_pkg::EMPTY_MV_RESET;
      full_mv  <= bscr_pkg::FULL_MV_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bscr_pkg::REG_EMPTY: empty_mv <= cfg_data;
        bscr_pkg::REG_FULL:  full_mv  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    prod1     = 29'(raw_sample) * 29'(bscr_pkg::MV_SCALE) + 29'(bscr_pkg::MV_BIAS);
    prod2     = 37'(y1) * 37'(bscr_pkg::DIV25_MUL);
    diff_c    = mv2 - empty_mv;
    span_c    = full_mv - empty_mv;
    num_c     = bscr_pkg::NUM_W'(diff_c) * bscr_pkg::NUM_W'(bscr_pkg::PCT_FULL)
              + bscr_pkg::NUM_W'(span_c >> 1);
    mvr_c     = mv2 + bscr_pkg::MV_W'(bscr_pkg::CV_ROUND);
    cv_prod   = 26'(mvr_c) * 26'(bscr_pkg::DIV10_MUL);
    cv_q      = bscr_pkg::CV_W'(cv_prod >> bscr_pkg::DIV10_SHIFT);
    cv_c      = (cv_q > bscr_pkg::CV_W'(bscr_pkg::CV_MAX)) ?
                bscr_pkg::CV_W'(bscr_pkg::CV_MAX) : cv_q;
    h_prod    = 23'(cv3) * 23'(bscr_pkg::DIV10_MUL);
    hund_prod = 19'(h4) * 19'(bscr_pkg::DIV10_MUL);
    ones_wide = cv4 - bscr_pkg::CV_W'(h4) * bscr_pkg::CV_W'(bscr_pkg::RADIX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y1    <= 18'(prod1 >> bscr_pkg::MV_SHIFT);
      mv2   <= bscr_pkg::MV_W'(prod2 >> bscr_pkg::DIV25_SHIFT);
      mv3   <= mv2;
      num3  <= num_c;
      span3 <= span_c;
      low3  <= (mv2 <= empty_mv);
      high3 <= (mv2 >= full_mv);
      cv3   <= cv_c;
      mv4   <= mv3;
      num4  <= num3;
      span4 <= span3;
      low4  <= low3;
      high4 <= high3;
      cv4   <= cv3;
      h4    <= bscr_pkg::CVT_W'(h_prod >> bscr_pkg::DIV10_SHIFT);
      num   <= num4;
      span  <= span4;
      side.mv      <= mv4;
      side.cv_tens <= h4;
      side.cv_hund <= bscr_pkg::DIGIT_W'(hund_prod >> bscr_pkg::DIV10_SHIFT);
      side.cv_ones <= bscr_pkg::DIGIT_W'(ones_wide);
      side.is_low  <= low4;
      side.is_high <= high4;
    end
  end

endmodule

@@ sv/bscr_pct_div.sv @@
module bscr_pct_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [bscr_pkg::NUM_W-1:0]    num,
  input  logic [bscr_pkg::MV_W-1:0]     span,
  input  bscr_pkg::side_t               side_in,
  output logic                          out_valid,
  output logic [bscr_pkg::PCT_W-1:0]    quot,
  output bscr_pkg::side_t               side_out
);

  localparam int STEPS = bscr_pkg::PCT_W;

  logic                          vld_in  [0:STEPS-1];
  logic [bscr_pkg::NUM_W-1:0]    rem_in  [0:STEPS-1];
  logic [bscr_pkg::MV_W-1:0]     spn_in  [0:STEPS-1];
  logic [bscr_pkg::PCT_W-1:0]    q_in    [0:STEPS-1];
  bscr_pkg::side_t               sd_in   [0:STEPS-1];

  logic                          vld_q   [0:STEPS-1];
  logic [bscr_pkg::NUM_W-1:0]    rem_q   [0:STEPS-1];
  logic [bscr_pkg::MV_W-1:0]     spn_q   [0:STEPS-1];
  logic [bscr_pkg::PCT_W-1:0]    q_q     [0:STEPS-1];
  bscr_pkg::side_t               sd_q    [0:STEPS-1];

  assign vld_in[0] = in_valid;
  assign rem_in[0] = num;
  assign spn_in[0] = span;
  assign q_in[0]   = '0;
  assign sd_in[0]  = side_in;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic [bscr_pkg::NUM_W-1:0] trial;
    logic                       fits;

    if (i > 0) begin : g_link
      assign vld_in[i] = vld_q[i-1];
      assign rem_in[i] = rem_q[i-1];
      assign spn_in[i] = spn_q[i-1];
      assign q_in[i]   = q_q[i-1];
      assign sd_in[i]  = sd_q[i-1];
    end

    // one quotient bit a stage, msb first
    assign trial = bscr_pkg::NUM_W'(spn_in[i]) << (STEPS - 1 - i);
    assign fits  = (rem_in[i] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= fits ? rem_in[i] - trial : rem_in[i];
        spn_q[i] <= spn_in[i];
        q_q[i]   <= {q_in[i][bscr_pkg::PCT_W-2:0], fits};
        sd_q[i]  <= sd_in[i];
      end
    end
  end

  assign out_valid = vld_q[STEPS-1];
  assign quot      = q_q[STEPS-1];
  assign side_out  = sd_q[STEPS-1];

  a_band_quot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !side_out.is_low && !side_out.is_high
      |-> quot <= bscr_pkg::PCT_W'(bscr_pkg::PCT_FULL))
    else $error("band quotient above full scale");

endmodule

@@ sv/bscr_format.sv @@
module bscr_format #(
  parameter int FRAME_COLUMNS = bscr_pkg::DEF_FRAME_COLUMNS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [bscr_pkg::PCT_W-1:0]    quot,
  input  bscr_pkg::side_t               side,
  output logic                          out_valid,
  output bscr_pkg::frame_t              frame
);

  logic                            v1;
  logic [bscr_pkg::PCT_W-1:0]      pct1;
  logic [bscr_pkg::DIGIT_W-1:0]    tens1;
  logic [bscr_pkg::MV_W-1:0]       mv1;
  logic [bscr_pkg::DIGIT_W-1:0]    hund1, mid1, ones1;

  logic [bscr_pkg::PCT_W-1:0]      pct_c;
  logic [14:0]                     tens_prod;
  logic [bscr_pkg::CVT_W-1:0]      mid_wide;
  logic [bscr_pkg::PCT_W-1:0]      pones_wide;
  bscr_pkg::glyph_t [bscr_pkg::TEXT_SLOTS-1:0] text_c;
  logic [bscr_pkg::LEN_W-1:0]      len_c;
  logic [bscr_pkg::COL_W-1:0]      width_c;
  logic [bscr_pkg::COL_W-1:0]      start_c;
  logic [bscr_pkg::COL_W:0]        gap_c;

  always_comb begin
    if (side.is_low) begin
      pct_c = '0;
    end else if (side.is_high || quot > bscr_pkg::PCT_W'(bscr_pkg::PCT_FULL)) begin
      pct_c = bscr_pkg::PCT_W'(bscr_pkg::PCT_FULL);
    end else begin
      pct_c = quot;
    end
    tens_prod = 15'(pct_c) * 15'(bscr_pkg::PCT_DIV10_MUL);
    mid_wide  = side.cv_tens
              - bscr_pkg::CVT_W'(side.cv_hund) * bscr_pkg::CVT_W'(bscr_pkg::RADIX);
  end

  always_comb begin
    pones_wide = pct1 - bscr_pkg::PCT_W'(tens1) * bscr_pkg::PCT_W'(bscr_pkg::RADIX);
    text_c     = {bscr_pkg::TEXT_SLOTS{bscr_pkg::GLYPH_SPACE}};
    text_c[0]  = hund1;
    text_c[1]  = bscr_pkg::GLYPH_DOT;
    text_c[2]  = mid1;
    text_c[3]  = ones1;
    text_c[4]  = bscr_pkg::GLYPH_VOLT;
    text_c[5]  = bscr_pkg::GLYPH_SPACE;
    if (pct1 >= bscr_pkg::PCT_W'(bscr_pkg::PCT_FULL)) begin
      text_c[6] = bscr_pkg::GLYPH_ONE;
      text_c[7] = bscr_pkg::GLYPH_ZERO;
      text_c[8] = bscr_pkg::GLYPH_ZERO;
      text_c[9] = bscr_pkg::GLYPH_PCT;
      len_c     = bscr_pkg::LEN_W'(10);
    end else if (pct1 >= bscr_pkg::PCT_W'(bscr_pkg::RADIX)) begin
      text_c[6] = tens1;
      text_c[7] = bscr_pkg::DIGIT_W'(pones_wide);
      text_c[8] = bscr_pkg::GLYPH_PCT;
      len_c     = bscr_pkg::LEN_W'(9);
    end else begin
      text_c[6] = bscr_pkg::DIGIT_W'(pones_wide);
      text_c[7] = bscr_pkg::GLYPH_PCT;
      len_c     = bscr_pkg::LEN_W'(8);
    end
    width_c = {len_c, 2'b00} - bscr_pkg::COL_W'(1);
    gap_c   = (bscr_pkg::COL_W + 1)'(FRAME_COLUMNS) - (bscr_pkg::COL_W + 1)'(width_c);
    start_c = ((bscr_pkg::COL_W + 1)'(width_c) < (bscr_pkg::COL_W + 1)'(FRAME_COLUMNS)) ?
              bscr_pkg::COL_W'(gap_c >> 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pct1        <= pct_c;
      tens1       <= bscr_pkg::DIGIT_W'(tens_prod >> bscr_pkg::PCT_DIV10_SHIFT);
      mv1         <= side.mv;
      hund1       <= side.cv_hund;
      mid1        <= bscr_pkg::DIGIT_W'(mid_wide);
      ones1       <= side.cv_ones;
      frame.text  <= text_c;
      frame.len   <= len_c;
      frame.start <= start_c;
      frame.mv    <= mv1;
      frame.pct   <= pct1;
    end
  end

endmodule

@@ sv/bscr_emitter.sv @@
module bscr_emitter #(
  parameter int FRAME_COLUMNS = bscr_pkg::DEF_FRAME_COLUMNS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bscr_pkg::frame_t              frame_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bscr_pkg::COL_W-1:0]    column_index,
  output logic [bscr_pkg::BITS_W-1:0]   column_bits,
  output logic [bscr_pkg::MV_W-1:0]     battery_millivolts,
  output logic [bscr_pkg::PCT_W-1:0]    charge_percent,
  output logic                          last_column
);

  localparam logic [bscr_pkg::COL_W-1:0] LAST_COL = bscr_pkg::COL_W'(FRAME_COLUMNS - 1);

  logic                          busy;
  logic [bscr_pkg::COL_W-1:0]    col;
  bscr_pkg::frame_t              frame;

  logic                          out_adv;
  logic                          at_last;
  logic                          load;
  logic [bscr_pkg::COL_W-1:0]    rel;
  logic                          lead_in;
  logic [bscr_pkg::LEN_W-1:0]    slot;
  logic                          in_text;
  bscr_pkg::glyph_t              glyph;
  logic [bscr_pkg::FONT_HEIGHT-1:0] pix;

  always_comb begin
    out_adv  = !out_valid || out_ready;
    at_last  = (col == LAST_COL);
    in_ready = !busy || (out_adv && at_last);
    load     = in_valid && in_ready;
    rel      = col - frame.start;
    lead_in  = (col < frame.start);
    slot     = rel[bscr_pkg::COL_W-1:2];
    in_text  = !lead_in && (slot < frame.len);
    glyph    = in_text ? frame.text[slot] : bscr_pkg::GLYPH_SPACE;
    pix      = bscr_pkg::glyph_column(glyph, rel[1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      col       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        col  <= '0;
      end else if (busy && out_adv && at_last) begin
        busy <= 1'b0;
      end else if (busy && out_adv) begin
        col <= col + bscr_pkg::COL_W'(1);
      end
      if (out_adv) begin
        out_valid <= busy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= frame_in;
    end
    if (busy && out_adv) begin
      column_index       <= col;
      column_bits        <= {pix, bscr_pkg::TOP_ROW'(0)};
      battery_millivolts <= frame.mv;
      charge_percent     <= frame.pct;
      last_column        <= at_last;
    end
  end

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_column |=> out_valid)
    else $error("column run broken before last column");

  a_column_steps: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_column
      |=> column_index == $past(column_index) + bscr_pkg::COL_W'(1))
    else $error("column index did not step by one");

  a_last_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_column |-> column_index == LAST_COL)
    else $error("last column marked on wrong column");

endmodule

@@ sv/battery_status_column_renderer_top.sv @@
// battery status column renderer
//
// s_tvalid/s_tready/s_tdata take one 12-bit adc sample per word. for each
// sample the block emits FRAME_COLUMNS column words on m_tvalid/m_tready/
// m_tdata, left to right, with m_tlast on the final column. each column word
// carries the lit pixels of the "d.ddV pp%" text plus the sample's millivolts
// and charge percent. cfg_write/cfg_index/cfg_data set the empty (index 0)
// and full (index 1) thresholds in millivolts.
//
// when the emitter is idle, a sample runs through the front, divider and
// format pipelines into the emitter, whose output register shows its first
// column word. the emitter sends one column a cycle unless m_tready is low; the
// next frame follows the last column of the previous one with no gap. up to
// 14 further samples wait in the arithmetic pipeline while a frame goes out.
//
// rst is synchronous: the pipeline empties and the thresholds return to
// 3300 and 4200 mV. when m_tready is low while m_tvalid is high the output
// word holds and the emitter freezes; once a finished frame waits for the
// emitter the whole pipeline freezes and s_tready drops.
module battery_status_column_renderer_top #(
  parameter int FRAME_COLUMNS = bscr_pkg::DEF_FRAME_COLUMNS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bscr_pkg::S_TDATA_W-1:0]    s_tdata,   // raw_sample
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // column_index, column_bits, battery_millivolts, charge_percent
  output logic [bscr_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_write,
  input  logic [bscr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bscr_pkg::CFG_W-1:0]        cfg_data
);

  logic                          en;
  logic                          front_valid;
  logic [bscr_pkg::NUM_W-1:0]    front_num;
  logic [bscr_pkg::MV_W-1:0]     front_span;
  bscr_pkg::side_t               front_side;
  logic                          div_valid;
  logic [bscr_pkg::PCT_W-1:0]    div_quot;
  bscr_pkg::side_t               div_side;
  logic                          fmt_valid;
  bscr_pkg::frame_t              fmt_frame;
  logic                          emit_ready;

  logic [bscr_pkg::COL_W-1:0]    column_index;
  logic [bscr_pkg::BITS_W-1:0]   column_bits;
  logic [bscr_pkg::MV_W-1:0]     battery_millivolts;
  logic [bscr_pkg::PCT_W-1:0]    charge_percent;

  assign en       = !fmt_valid || emit_ready;
  assign s_tready = en;

  bscr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .raw_sample (s_tdata[bscr_pkg::RAW_W-1:0]),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (front_valid),
    .num        (front_num),
    .span       (front_span),
    .side       (front_side)
  );

  bscr_pct_div u_pct_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .num       (front_num),
    .span      (front_span),
    .side_in   (front_side),
    .out_valid (div_valid),
    .quot      (div_quot),
    .side_out  (div_side)
  );

  bscr_format #(
    .FRAME_COLUMNS (FRAME_COLUMNS)
  ) u_format (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .quot      (div_quot),
    .side      (div_side),
    .out_valid (fmt_valid),
    .frame     (fmt_frame)
  );

  bscr_emitter #(
    .FRAME_COLUMNS (FRAME_COLUMNS)
  ) u_emitter (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (fmt_valid),
    .in_ready           (emit_ready),
    .frame_in           (fmt_frame),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .column_index       (column_index),
    .column_bits        (column_bits),
    .battery_millivolts (battery_millivolts),
    .charge_percent     (charge_percent),
    .last_column        (m_tlast)
  );

  assign m_tdata = {6'b000000, charge_percent, battery_millivolts, column_bits, column_index};

endmodule
